[rtl/core_hotplug_mode_governor_defines.svh]
// assertion macros used by the governor rtl
`ifndef CORE_HOTPLUG_MODE_GOVERNOR_DEFINES_SVH
`define CORE_HOTPLUG_MODE_GOVERNOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HPG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define HPG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/hpg_pkg.sv]
package hpg_pkg;

  localparam int NUM_CORES = 4;
  localparam int NUM_LANES = 3;
  localparam int NUM_SEC = ((NUM_CORES - 1) > NUM_LANES) ? NUM_LANES : (NUM_CORES - 1);
  localparam logic [NUM_LANES-1:0] SEC_MASK = NUM_LANES'((1 << NUM_SEC) - 1);

  localparam logic [6:0]  RST_COLD_LEVEL = 7'd20;
  localparam logic [21:0] RST_LOW_FREQ_LIMIT = 22'd250000;
  localparam logic [21:0] RST_HIGH_FREQ_LIMIT = 22'd1900000;
  localparam logic [21:0] RST_BOOST_CAP = 22'd2100000;

  localparam logic [6:0] DELAY_SLOW = 7'd100;
  localparam logic [6:0] DELAY_FAST = 7'd10;
  localparam logic [2:0] LOW_RUN_SAT = 3'd6;
  localparam logic [2:0] LOW_RUN_MIN = 3'd5;
  localparam logic [3:0] HIGH_RUN_SAT = 4'd15;
  localparam logic [3:0] HIGH_RUN_DIRECT = 4'd3;
  localparam logic [3:0] HIGH_RUN_SIMPLE = 4'd5;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_LOW    = 2'd1,
    MODE_HIGH   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CFG_COLD_LEVEL       = 3'd0,
    CFG_LOW_FREQ_LIMIT   = 3'd1,
    CFG_HIGH_FREQ_LIMIT  = 3'd2,
    CFG_BOOST_CAP        = 3'd3,
    CFG_HIGH_PERF_ENABLE = 3'd4,
    CFG_SIMPLE_BOOST     = 3'd5
  } cfg_idx_t;

  // per-core flags from one lane
  typedef struct packed {
    logic cold;
    logic online;
  } lane_t;

  // merged view of all lanes
  typedef struct packed {
    logic                 cold_pair;
    logic                 take_ok;
    logic [NUM_LANES-1:0] take_mask;
    logic [NUM_LANES-1:0] online_mask;
    logic                 full;
  } merge_t;

endpackage

[rtl/hpg_tick_if.sv]
interface hpg_tick_if;
  logic        valid;
  logic        ready;
  logic [21:0] cur_freq;
  logic [6:0]  util_core1;
  logic [6:0]  util_core2;
  logic [6:0]  util_core3;
  logic [2:0]  online_cores;
  logic        display_on;

  modport source (output valid, cur_freq, util_core1, util_core2, util_core3,
                  online_cores, display_on, input ready);
  modport sink (input valid, cur_freq, util_core1, util_core2, util_core3,
                online_cores, display_on, output ready);
endinterface

[rtl/hpg_result_if.sv]
interface hpg_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        apply_online;
  logic [2:0]  online_targets;
  logic        cap_valid;
  logic [21:0] freq_cap;
  logic [6:0]  poll_delay_ms;

  modport source (output valid, mode, apply_online, online_targets, cap_valid,
                  freq_cap, poll_delay_ms, input ready);
  modport sink (input valid, mode, apply_online, online_targets, cap_valid,
                freq_cap, poll_delay_ms, output ready);
endinterface

[rtl/core_hotplug_mode_governor.sv]
// channel   | role   | payload
// ----------+--------+------------------------------------------------------------
// tick      | sink   | cur_freq, util_core1..3, online_cores, display_on
// result    | source | mode, apply_online, online_targets, cap_valid, freq_cap,
//           |        | poll_delay_ms
// cfg       | write  | cfg_wr_en, cfg_index, cfg_data (no read-back)
//
// one item per cycle while the result is not stalled; a result appears in the cycle after its tick is accepted
// the decision is combinational, so the rate is set only by the output register
// reset (rst, synchronous) empties the output register, restores register defaults
// a stalled result holds the output register; a tick is still taken when the
// result is being drained in the same cycle
`include "core_hotplug_mode_governor_defines.svh"

module core_hotplug_mode_governor (
  input  logic                clk,
  input  logic                rst,
  hpg_tick_if.sink            tick,
  hpg_result_if.source        result,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [21:0]         cfg_data
);

  // configuration registers
  logic [6:0]  cold_level;
  logic [21:0] low_freq_limit;
  logic [21:0] high_freq_limit;
  logic [21:0] boost_cap;
  logic        high_perf_enable;
  logic        simple_boost;

  // governor state
  logic [2:0]     low_run, low_run_next;
  logic [3:0]     high_run, high_run_next;
  hpg_pkg::mode_t held_mode, held_mode_next;
  logic [6:0]     delay_reg, delay_reg_next;

  // output register
  logic        out_valid;
  logic [1:0]  out_mode;
  logic        out_apply;
  logic [2:0]  out_targets;
  logic        out_capv;
  logic [21:0] out_cap;
  logic [6:0]  out_delay;

  logic accept;
  logic hp_pick;
  logic [3:0] high_run_cnt;
  hpg_pkg::mode_t mode_c;
  logic        apply_c;
  logic [2:0]  targets_c;
  logic        capv_c;
  logic [21:0] cap_c;

  hpg_pkg::lane_t  lanes [hpg_pkg::NUM_LANES];
  hpg_pkg::merge_t merged;
  logic [6:0]      util_vec [hpg_pkg::NUM_LANES];

  // skid: take a tick when the output slot is free or being drained
  assign tick.ready = !out_valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  assign util_vec[0] = tick.util_core1;
  assign util_vec[1] = tick.util_core2;
  assign util_vec[2] = tick.util_core3;

  // one lane per secondary core slot; absent cores are masked off in the lane
  for (genvar g = 0; g < hpg_pkg::NUM_LANES; g++) begin : g_lane
    hpg_lane u_lane (
      .exists     (hpg_pkg::SEC_MASK[g]),
      .util       (util_vec[g]),
      .cold_level (cold_level),
      .online_bit (tick.online_cores[g]),
      .flags      (lanes[g])
    );
  end

  hpg_merge u_merge (
    .lanes  (lanes),
    .merged (merged)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cold_level       <= hpg_pkg::RST_COLD_LEVEL;
      low_freq_limit   <= hpg_pkg::RST_LOW_FREQ_LIMIT;
      high_freq_limit  <= hpg_pkg::RST_HIGH_FREQ_LIMIT;
      boost_cap        <= hpg_pkg::RST_BOOST_CAP;
      high_perf_enable <= 1'b1;
      simple_boost     <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hpg_pkg::CFG_COLD_LEVEL:       cold_level       <= cfg_data[6:0];
        hpg_pkg::CFG_LOW_FREQ_LIMIT:   low_freq_limit   <= cfg_data;
        hpg_pkg::CFG_HIGH_FREQ_LIMIT:  high_freq_limit  <= cfg_data;
        hpg_pkg::CFG_BOOST_CAP:        boost_cap        <= cfg_data;
        hpg_pkg::CFG_HIGH_PERF_ENABLE: high_perf_enable <= cfg_data[0];
        hpg_pkg::CFG_SIMPLE_BOOST:     simple_boost     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // mode decision
  always_comb begin
    // low-frequency run, saturating at six
    if (tick.cur_freq > low_freq_limit) low_run_next = 3'd0;
    else if (low_run <= hpg_pkg::LOW_RUN_MIN) low_run_next = low_run + 3'd1;
    else low_run_next = low_run;
    if (low_run_next > hpg_pkg::LOW_RUN_MIN && !tick.display_on) mode_c = hpg_pkg::MODE_LOW;
    else mode_c = hpg_pkg::MODE_NORMAL;

    // high-frequency run, saturating at fifteen
    if (tick.cur_freq < high_freq_limit) high_run_cnt = 4'd0;
    else if (high_run < hpg_pkg::HIGH_RUN_SAT) high_run_cnt = high_run + 4'd1;
    else high_run_cnt = high_run;

    if (simple_boost) hp_pick = high_perf_enable && (high_run_cnt > hpg_pkg::HIGH_RUN_SIMPLE);
    else hp_pick = high_perf_enable && (high_run_cnt > hpg_pkg::HIGH_RUN_DIRECT) &&
                   merged.cold_pair;
    // choosing high performance clears the run even if the entry fails later
    high_run_next = hp_pick ? 4'd0 : high_run_cnt;
    if (hp_pick) mode_c = hpg_pkg::MODE_HIGH;

    held_mode_next = mode_c;
    delay_reg_next = delay_reg;
    apply_c   = 1'b0;
    targets_c = 3'd0;
    capv_c    = 1'b0;
    cap_c     = 22'd0;

    if (mode_c != held_mode) begin
      case (mode_c)
        hpg_pkg::MODE_LOW: begin
          // flip every existing core
          delay_reg_next = hpg_pkg::DELAY_SLOW;
          apply_c   = 1'b1;
          targets_c = hpg_pkg::SEC_MASK & ~merged.online_mask;
          capv_c    = 1'b1;
          cap_c     = high_freq_limit;
        end
        hpg_pkg::MODE_HIGH: begin
          if (!simple_boost) begin
            if (merged.take_ok) begin
              // park the two picked cold cores, bring the rest up
              apply_c   = 1'b1;
              targets_c = hpg_pkg::SEC_MASK & ~merged.take_mask;
              capv_c    = 1'b1;
              cap_c     = boost_cap;
              delay_reg_next = hpg_pkg::DELAY_FAST;
            end else begin
              // not enough cold online cores: stay where we were
              held_mode_next = held_mode;
            end
          end else begin
            apply_c   = !merged.full;
            targets_c = merged.full ? 3'd0 : hpg_pkg::SEC_MASK;
            capv_c    = 1'b1;
            cap_c     = boost_cap;
          end
        end
        default: begin
          // back to normal
          delay_reg_next = hpg_pkg::DELAY_SLOW;
          capv_c    = 1'b1;
          cap_c     = high_freq_limit;
          apply_c   = !merged.full;
          targets_c = merged.full ? 3'd0 : hpg_pkg::SEC_MASK;
        end
      endcase
    end
  end

  // state update on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      low_run   <= 3'd0;
      high_run  <= 4'd0;
      held_mode <= hpg_pkg::MODE_NORMAL;
      delay_reg <= hpg_pkg::DELAY_SLOW;
    end else if (accept) begin
      low_run   <= low_run_next;
      high_run  <= high_run_next;
      held_mode <= held_mode_next;
      delay_reg <= delay_reg_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_mode    <= held_mode_next;
      out_apply   <= apply_c;
      out_targets <= targets_c;
      out_capv    <= capv_c;
      out_cap     <= cap_c;
      out_delay   <= delay_reg_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.mode           = out_mode;
  assign result.apply_online   = out_apply;
  assign result.online_targets = out_targets;
  assign result.cap_valid      = out_capv;
  assign result.freq_cap       = out_cap;
  assign result.poll_delay_ms  = out_delay;

  `HPG_ASSERT_NEXT(a_tick_gives_result, clk, rst, accept, out_valid, "accepted tick lost")
  `HPG_ASSERT_NEXT(a_hp_clears_run, clk, rst, accept && hp_pick, high_run == 4'd0, "high run not cleared")
  `HPG_ASSERT_NOW(a_targets_exist, clk, rst, out_valid, (out_targets & ~hpg_pkg::SEC_MASK) == 3'd0, "target for absent core")
  `HPG_ASSERT_NOW(a_low_entry_delay, clk, rst, out_valid && out_capv && out_mode == hpg_pkg::MODE_LOW, out_delay == hpg_pkg::DELAY_SLOW, "low entry delay wrong")

endmodule

[rtl/hpg_lane.sv]
module hpg_lane (
  input  logic          exists,
  input  logic [6:0]    util,
  input  logic [6:0]    cold_level,
  input  logic          online_bit,
  output hpg_pkg::lane_t flags
);
  always_comb begin
    flags.cold   = exists && (util <= cold_level);
    flags.online = exists && online_bit;
  end
endmodule

[rtl/hpg_merge.sv]
module hpg_merge (
  input  hpg_pkg::lane_t  lanes [hpg_pkg::NUM_LANES],
  output hpg_pkg::merge_t merged
);
  logic [1:0] cold_cnt;
  logic [1:0] take_cnt;
  logic [1:0] online_cnt;
  logic [3:0] total_online;

  always_comb begin
    cold_cnt   = 2'd0;
    take_cnt   = 2'd0;
    online_cnt = 2'd0;
    merged.take_mask   = '0;
    merged.online_mask = '0;
    // lowest-numbered online cold cores are picked first, two at most
    for (int i = 0; i < hpg_pkg::NUM_LANES; i++) begin
      merged.online_mask[i] = lanes[i].online;
      if (lanes[i].cold) cold_cnt = cold_cnt + 2'd1;
      if (lanes[i].online) online_cnt = online_cnt + 2'd1;
      if (lanes[i].online && lanes[i].cold && (take_cnt < 2'd2)) begin
        merged.take_mask[i] = 1'b1;
        take_cnt = take_cnt + 2'd1;
      end
    end
    merged.cold_pair = (cold_cnt >= 2'd2);
    merged.take_ok   = (take_cnt == 2'd2);
    total_online     = {2'b00, online_cnt} + 4'd1;
    merged.full      = (total_online >= 4'(hpg_pkg::NUM_CORES));
  end
endmodule
